// ----- rtl/plp_pkg.sv -----
// Shared types and constants for the polyline path length unit.
package plp_pkg;

    localparam int POS_WIDTH_DEF  = 24;
    localparam int COST_WIDTH_DEF = 40;

    // Number of coordinate axes squared per step.
    localparam int NUM_AXES = 3;

    // Segment point count codes (saturating).
    localparam logic [1:0] CNT_NONE = 2'd0;
    localparam logic [1:0] CNT_ONE  = 2'd1;
    localparam logic [1:0] CNT_MANY = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_ROOT,
        ST_ACCUM,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic       load;
        logic       mul_en;
        logic [1:0] mul_sel;
        logic       add_en;
        logic       root_step;
        logic       accum;
        logic       emit;
    } t_dp_cmd;

    typedef struct packed {
        logic need_dist;
        logic in_last;
        logic last_held;
        logic out_free;
    } t_dp_status;

endpackage

// ----- rtl/plp_ctrl.sv -----
// Sequencing state machine for the polyline path length unit.
module plp_ctrl #(
    parameter int ROOT_STEPS = plp_pkg::POS_WIDTH_DEF + 1
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  plp_pkg::t_dp_status i_status,
    output plp_pkg::t_dp_cmd    o_cmd
);
    import plp_pkg::*;

    localparam int CNTW = $clog2(ROOT_STEPS);

    t_state            r_state, n_state;
    logic [CNTW-1:0]   r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_cnt      = '0;
                    if (i_status.need_dist) begin
                        n_state = ST_SQUARE;
                    end else if (i_status.in_last) begin
                        n_state = ST_EMIT;
                    end
                end
            end
            ST_SQUARE: begin
                // Multiply axis k while adding the product of axis k-1.
                o_cmd.mul_en  = (r_cnt != CNTW'(NUM_AXES));
                o_cmd.mul_sel = r_cnt[1:0];
                o_cmd.add_en  = (r_cnt != '0);
                if (r_cnt == CNTW'(NUM_AXES)) begin
                    n_state = ST_ROOT;
                    n_cnt   = '0;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_ROOT: begin
                o_cmd.root_step = 1'b1;
                if (r_cnt == CNTW'(ROOT_STEPS - 1)) begin
                    n_state = ST_ACCUM;
                    n_cnt   = '0;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_ACCUM: begin
                o_cmd.accum = 1'b1;
                n_state     = i_status.last_held ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/plp_datapath.sv -----
// Datapath: point registers, squared distance, bit-serial root, length and result.
module plp_datapath #(
    parameter int POS_WIDTH  = plp_pkg::POS_WIDTH_DEF,
    parameter int COST_WIDTH = plp_pkg::COST_WIDTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_valid,
    input  logic                        i_cfg_data,
    input  logic signed [POS_WIDTH-1:0] i_pos_x,
    input  logic signed [POS_WIDTH-1:0] i_pos_y,
    input  logic signed [POS_WIDTH-1:0] i_pos_z,
    input  logic                        i_first_point,
    input  logic                        i_end_point,
    input  logic                        i_has_parent,
    input  logic [COST_WIDTH-1:0]       i_parent_cost,
    input  plp_pkg::t_dp_cmd            i_cmd,
    output plp_pkg::t_dp_status         o_status,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [COST_WIDTH-1:0]       o_path_cost,
    output logic                        o_cost_valid
);
    import plp_pkg::*;

    localparam int PW   = POS_WIDTH;
    localparam int CW   = COST_WIDTH;
    localparam int SW   = 2 * PW + 2;              // sum of three squares
    localparam int RW   = PW + 1;                  // root width
    localparam int REMW = RW + 3;                  // root remainder
    localparam int AW   = ((CW > RW) ? CW : RW) + 1;
    localparam logic [CW-1:0] CMAX = {CW{1'b1}};

    // Control and segment state
    logic            r_accumulate;
    logic [1:0]      r_count;
    logic            r_last;
    logic            r_out_valid;
    // Payload
    logic [PW-1:0]   r_prev_x, r_prev_y, r_prev_z;
    logic [PW-1:0]   r_dx, r_dy, r_dz;
    logic [2*PW-1:0] r_prod;
    logic [SW-1:0]   r_sum;
    logic [REMW-1:0] r_rem;
    logic [RW-1:0]   r_root;
    logic [CW-1:0]   r_running;
    logic            r_has_parent;
    logic [CW-1:0]   r_parent_cost;
    logic [CW-1:0]   r_path_cost;
    logic            r_cost_valid;

    logic            w_need_dist;
    logic [PW:0]     w_dx, w_dy, w_dz;
    logic [PW-1:0]   w_mul_in;
    logic [2*PW-1:0] w_prod;
    logic [REMW-1:0] w_rem_sh, w_trial;
    logic [AW-1:0]   w_len_sum;
    logic [CW-1:0]   w_len_sat;
    logic [CW:0]     w_par_sum;
    logic [CW-1:0]   w_par_sat;
    logic            w_count_many;

    assign w_need_dist  = !i_first_point && (r_count != CNT_NONE);
    assign w_count_many = (r_count == CNT_MANY);

    assign o_status.need_dist = w_need_dist;
    assign o_status.in_last   = i_end_point;
    assign o_status.last_held = r_last;
    assign o_status.out_free  = !r_out_valid || i_out_ready;

    // Signed differences, one bit wider than a coordinate.
    assign w_dx = {i_pos_x[PW-1], i_pos_x} - {r_prev_x[PW-1], r_prev_x};
    assign w_dy = {i_pos_y[PW-1], i_pos_y} - {r_prev_y[PW-1], r_prev_y};
    assign w_dz = {i_pos_z[PW-1], i_pos_z} - {r_prev_z[PW-1], r_prev_z};

    function automatic logic [PW-1:0] abs_diff(input logic [PW:0] d);
        logic [PW:0] m;
        m = d[PW] ? (~d + 1'b1) : d;
        return m[PW-1:0];
    endfunction

    always_comb begin
        unique case (i_cmd.mul_sel)
            2'd0:    w_mul_in = r_dx;
            2'd1:    w_mul_in = r_dy;
            default: w_mul_in = r_dz;
        endcase
    end
    assign w_prod = {{PW{1'b0}}, w_mul_in} * {{PW{1'b0}}, w_mul_in};

    // One radicand digit pair per step.
    assign w_rem_sh = {r_rem[REMW-3:0], r_sum[SW-1:SW-2]};
    assign w_trial  = REMW'({r_root, 2'b01});

    assign w_len_sum = AW'(r_running) + AW'(r_root);
    assign w_len_sat = (w_len_sum > AW'(CMAX)) ? CMAX : w_len_sum[CW-1:0];
    assign w_par_sum = {1'b0, r_running} + {1'b0, r_parent_cost};
    assign w_par_sat = w_par_sum[CW] ? CMAX : w_par_sum[CW-1:0];

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accumulate <= 1'b0;
            r_count      <= CNT_NONE;
            r_last       <= 1'b0;
            r_out_valid  <= 1'b0;
            r_prev_x     <= '0;
            r_prev_y     <= '0;
            r_prev_z     <= '0;
            r_running    <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_accumulate <= i_cfg_data;
            end
            if (i_cmd.load) begin
                r_last   <= i_end_point;
                r_prev_x <= i_pos_x;
                r_prev_y <= i_pos_y;
                r_prev_z <= i_pos_z;
                if (!w_need_dist) begin
                    r_running <= '0;
                    r_count   <= CNT_ONE;
                end
            end
            if (i_cmd.accum) begin
                r_running <= w_len_sat;
                r_count   <= CNT_MANY;
            end
            if (i_cmd.emit) begin
                r_running   <= '0;
                r_count     <= CNT_NONE;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_dx          <= abs_diff(w_dx);
            r_dy          <= abs_diff(w_dy);
            r_dz          <= abs_diff(w_dz);
            r_sum         <= '0;
            r_rem         <= '0;
            r_root        <= '0;
            r_has_parent  <= i_has_parent;
            r_parent_cost <= i_parent_cost;
        end else if (i_cmd.root_step) begin
            r_sum <= {r_sum[SW-3:0], 2'b00};
            if (w_rem_sh >= w_trial) begin
                r_rem  <= w_rem_sh - w_trial;
                r_root <= {r_root[RW-2:0], 1'b1};
            end else begin
                r_rem  <= w_rem_sh;
                r_root <= {r_root[RW-2:0], 1'b0};
            end
        end else if (i_cmd.add_en) begin
            r_sum <= r_sum + SW'(r_prod);
        end
        if (i_cmd.mul_en) begin
            r_prod <= w_prod;
        end
        if (i_cmd.emit) begin
            r_cost_valid <= w_count_many;
            if (!w_count_many) begin
                r_path_cost <= '0;
            end else if (r_accumulate && r_has_parent) begin
                r_path_cost <= w_par_sat;
            end else begin
                r_path_cost <= r_running;
            end
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_path_cost  = r_path_cost;
    assign o_cost_valid = r_cost_valid;

    // Point count saturates at two.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != 2'd3)
        else $error("point count out of range");

    // A result clears the segment.
    a_emit_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |=> (r_count == CNT_NONE) && (r_running == '0) && r_out_valid)
        else $error("segment not cleared after result");

    // A short-segment result carries zero cost.
    a_short_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_cost_valid) |-> (r_path_cost == '0))
        else $error("short segment with nonzero cost");

    // A new result is only loaded when the output register can take it.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> (!r_out_valid || i_out_ready))
        else $error("result overwritten");

endmodule

// ----- rtl/polyline_path_length_unit.sv -----
// Polyline path length unit: top level joining controller and datapath.
//
// Takes one 3D point per transaction and sums the truncated integer square
// root of each step's squared Euclidean distance into a saturating segment
// length. The point flagged end_point yields one result transaction:
// path_cost (plus parent_cost when accumulate_parent is set and has_parent is
// high, saturating) and cost_valid, which is low with zero cost for a segment
// of fewer than two points. A point that arrives with no segment open starts
// one. A point that opens a segment needs only the idle state (and the emit
// state if it also closes it); any other point passes the square, root and
// accumulate states, then the emit state if it is the last, and no point is
// taken meanwhile. The square root resolves one root bit per cycle over the
// (2*POS_WIDTH + 2)-bit radicand, and one shared multiplier squares the three
// axis differences in turn. A finished result sits in an output register, so
// the next point is taken while the result waits. The config channel is
// always ready and must be written only while the unit is idle.
module polyline_path_length_unit #(
    parameter int POS_WIDTH  = plp_pkg::POS_WIDTH_DEF,
    parameter int COST_WIDTH = plp_pkg::COST_WIDTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // configuration write channel
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic                        i_cfg_accumulate_parent,
    // point channel
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic signed [POS_WIDTH-1:0] i_pos_x,
    input  logic signed [POS_WIDTH-1:0] i_pos_y,
    input  logic signed [POS_WIDTH-1:0] i_pos_z,
    input  logic                        i_first_point,
    input  logic                        i_end_point,
    input  logic                        i_has_parent,
    input  logic [COST_WIDTH-1:0]       i_parent_cost,
    // result channel
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [COST_WIDTH-1:0]       o_path_cost,
    output logic                        o_cost_valid
);
    import plp_pkg::*;

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    assign o_cfg_ready = 1'b1;

    // Sequencer: accept, square three axes, root, accumulate, emit.
    plp_ctrl #(
        .ROOT_STEPS (POS_WIDTH + 1)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    plp_datapath #(
        .POS_WIDTH  (POS_WIDTH),
        .COST_WIDTH (COST_WIDTH)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_data    (i_cfg_accumulate_parent),
        .i_pos_x       (i_pos_x),
        .i_pos_y       (i_pos_y),
        .i_pos_z       (i_pos_z),
        .i_first_point (i_first_point),
        .i_end_point   (i_end_point),
        .i_has_parent  (i_has_parent),
        .i_parent_cost (i_parent_cost),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_path_cost   (o_path_cost),
        .o_cost_valid  (o_cost_valid)
    );

endmodule
